FILE: rtl/core/hsec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsec_pkg
// Shared widths and codes for the Hamming SEC encoder/corrector.
// ----------------------------------------------------------------------------
package hsec_pkg;

  localparam int MSG_W     = 57;  // max message bits
  localparam int CODE_W    = 63;  // max codeword bits
  localparam int PAR_W     = 6;   // max parity bits
  localparam int LEN_W     = 6;   // message / code length fields
  localparam int SYN_W     = 6;
  localparam int STAT_W    = 2;
  localparam int CFG_W     = 6;   // widest config register
  localparam int CFG_IDX_W = 1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ODD     = 1'd1;

  // opcodes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_CORRECTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND    = 2'd2;

  localparam logic [LEN_W-1:0] MSG_LEN_RESET = 6'd4;

endpackage : hsec_pkg
`default_nettype wire

FILE: rtl/core/hsec_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsec_in_if
// Request channel: opcode, message word and received word.
// ----------------------------------------------------------------------------
interface hsec_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [hsec_pkg::MSG_W-1:0]      message_word;
  logic [hsec_pkg::CODE_W-1:0]     received_word;

  modport source (output valid, op, message_word, received_word, input ready);
  modport sink   (input valid, op, message_word, received_word, output ready);
endinterface : hsec_in_if
`default_nettype wire

FILE: rtl/core/hsec_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsec_out_if
// Result channel: codeword, data bits, syndrome and status.
// ----------------------------------------------------------------------------
interface hsec_out_if;
  logic                            valid;
  logic                            ready;
  logic [hsec_pkg::CODE_W-1:0]     code_word;
  logic [hsec_pkg::MSG_W-1:0]      data_out;
  logic [hsec_pkg::SYN_W-1:0]      syndrome;
  logic [hsec_pkg::STAT_W-1:0]     status;

  modport source (output valid, code_word, data_out, syndrome, status, input ready);
  modport sink   (input valid, code_word, data_out, syndrome, status, output ready);
endinterface : hsec_out_if
`default_nettype wire

FILE: rtl/core/hamming_sec_encode_correct.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hamming_sec_encode_correct
// Hamming single-error-correcting encoder / corrector, three-stage pipeline.
// ----------------------------------------------------------------------------
// Each accepted item passes the stage 1, 2 and 3 registers to reach out_ch.
// Throughput: one item per cycle while out_ch.ready is high; a stage holds
//   one item, advances when the next is empty or moving; a stall only freezes.
// Reset (rst, synchronous): clears all stage valid bits, message_length = 4,
//   odd_parity = 0 (code length 7). Payload registers are not reset.
// ----------------------------------------------------------------------------
module hamming_sec_encode_correct (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hsec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hsec_pkg::CFG_W-1:0]      cfg_data,
  hsec_in_if.sink                              in_ch,
  hsec_out_if.source                           out_ch
);

  // --------------------------------------------------------------------------
  // Helper functions (all fixed wiring / small loops over independent bits)
  // --------------------------------------------------------------------------

  // Saturate raw message length to the supported maximum.
  function automatic logic [hsec_pkg::LEN_W-1:0] sat_len(
    input logic [hsec_pkg::LEN_W-1:0] m
  );
    sat_len = (m > hsec_pkg::LEN_W'(hsec_pkg::MSG_W)) ?
              hsec_pkg::LEN_W'(hsec_pkg::MSG_W) : m;
  endfunction

  // Code length n = m + r, r smallest with m + r + 1 <= 2^r (r capped at 6).
  function automatic logic [hsec_pkg::LEN_W-1:0] calc_code_len(
    input logic [hsec_pkg::LEN_W-1:0] m_sat
  );
    logic [2:0] r;
    logic [7:0] n;
    r = 3'd1;
    for (int j = 1; j < hsec_pkg::PAR_W; j++) begin
      if (8'(m_sat) + 8'(r) + 8'd1 > (8'd1 << r)) begin
        r = r + 3'd1;
      end
    end
    n = 8'(m_sat) + 8'(r);
    if (n > 8'(hsec_pkg::CODE_W)) begin
      n = 8'(hsec_pkg::CODE_W);
    end
    calc_code_len = n[hsec_pkg::LEN_W-1:0];
  endfunction

  // True for codeword positions (1-based) that hold parity.
  function automatic logic is_pow2(input int q);
    is_pow2 = (q != 0) && ((q & (q - 1)) == 0);
  endfunction

  // Message bits, lowest first, onto the non-power-of-two positions.
  function automatic logic [hsec_pkg::CODE_W-1:0] scatter(
    input logic [hsec_pkg::MSG_W-1:0] msg
  );
    int k;
    scatter = '0;
    k = 0;
    for (int q = 1; q <= hsec_pkg::CODE_W; q++) begin
      if (!is_pow2(q)) begin
        scatter[q-1] = msg[k];
        k++;
      end
    end
  endfunction

  // Inverse of scatter.
  function automatic logic [hsec_pkg::MSG_W-1:0] gather(
    input logic [hsec_pkg::CODE_W-1:0] word
  );
    int k;
    gather = '0;
    k = 0;
    for (int q = 1; q <= hsec_pkg::CODE_W; q++) begin
      if (!is_pow2(q)) begin
        gather[k] = word[q-1];
        k++;
      end
    end
  endfunction

  // Positions covered by parity check j (position bit j set).
  function automatic logic [hsec_pkg::CODE_W-1:0] cover_mask(input int j);
    cover_mask = '0;
    for (int q = 1; q <= hsec_pkg::CODE_W; q++) begin
      cover_mask[q-1] = ((q >> j) & 1) == 1;
    end
  endfunction

  // Low mask of len bits over a codeword.
  function automatic logic [hsec_pkg::CODE_W-1:0] code_mask(
    input logic [hsec_pkg::LEN_W-1:0] len
  );
    for (int i = 0; i < hsec_pkg::CODE_W; i++) begin
      code_mask[i] = (7'(i) < 7'(len));
    end
  endfunction

  function automatic logic [hsec_pkg::MSG_W-1:0] msg_mask(
    input logic [hsec_pkg::LEN_W-1:0] len
  );
    for (int i = 0; i < hsec_pkg::MSG_W; i++) begin
      msg_mask[i] = (7'(i) < 7'(len));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration. Code length is worked out at write time so the datapath
  // only ever sees the ready-made value.
  // --------------------------------------------------------------------------
  logic [hsec_pkg::LEN_W-1:0] msg_len;     // saturated m
  logic [hsec_pkg::LEN_W-1:0] code_len;    // n
  logic                       odd_parity;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_len    <= hsec_pkg::MSG_LEN_RESET;
      code_len   <= calc_code_len(hsec_pkg::MSG_LEN_RESET);
      odd_parity <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsec_pkg::CFG_MSG_LEN: begin
          msg_len  <= sat_len(cfg_data);
          code_len <= calc_code_len(sat_len(cfg_data));
        end
        hsec_pkg::CFG_ODD: begin
          odd_parity <= cfg_data[0];
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: a stage moves when the one after it is empty or moving.
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid;
  logic adv1, adv2, adv3;

  assign adv3 = !s3_valid || out_ch.ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;

  assign in_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_ch.valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: build the working word.
  //   encode: message masked to m bits, spread over data positions
  //   decode: received word masked to n bits
  // --------------------------------------------------------------------------
  logic                          s1_op;
  logic [hsec_pkg::CODE_W-1:0]   s1_word;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_op <= in_ch.op;
      if (in_ch.op == hsec_pkg::OP_DECODE) begin
        s1_word <= in_ch.received_word & code_mask(code_len);
      end else begin
        s1_word <= scatter(in_ch.message_word & msg_mask(msg_len));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: six parity trees. Parity positions of an encode word are still
  // zero, so the same XOR gives the parity bit on encode and the syndrome bit
  // on decode. Checks whose position lies beyond n are forced off.
  // --------------------------------------------------------------------------
  logic [hsec_pkg::PAR_W-1:0]    par;
  logic [hsec_pkg::CODE_W-1:0]   enc_word;
  logic                          s2_op;
  logic [hsec_pkg::CODE_W-1:0]   s2_word;
  logic [hsec_pkg::SYN_W-1:0]    s2_syn;

  always_comb begin
    for (int j = 0; j < hsec_pkg::PAR_W; j++) begin
      par[j] = ((7'd1 << j) <= 7'(code_len)) ?
               ((^(s1_word & cover_mask(j))) ^ odd_parity) : 1'b0;
    end
    enc_word = s1_word;
    for (int j = 0; j < hsec_pkg::PAR_W; j++) begin
      enc_word[(1 << j) - 1] = par[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_op <= s1_op;
      if (s1_op == hsec_pkg::OP_DECODE) begin
        s2_word <= s1_word;
        s2_syn  <= par;
      end else begin
        s2_word <= enc_word;
        s2_syn  <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: correction and data extraction, then the output register.
  // A syndrome that addresses a position past n flips nothing (status beyond).
  // --------------------------------------------------------------------------
  logic [hsec_pkg::CODE_W-1:0]   fix_word;
  logic [hsec_pkg::STAT_W-1:0]   fix_status;
  logic [hsec_pkg::CODE_W-1:0]   s3_word;
  logic [hsec_pkg::MSG_W-1:0]    s3_data;
  logic [hsec_pkg::SYN_W-1:0]    s3_syn;
  logic [hsec_pkg::STAT_W-1:0]   s3_status;

  always_comb begin
    fix_word   = s2_word;
    fix_status = hsec_pkg::ST_OK;
    if (s2_op == hsec_pkg::OP_DECODE && s2_syn != '0) begin
      if (s2_syn <= code_len) begin
        fix_word   = s2_word ^ (hsec_pkg::CODE_W'(1) << (s2_syn - 6'd1));
        fix_status = hsec_pkg::ST_CORRECTED;
      end else begin
        fix_status = hsec_pkg::ST_BEYOND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_word   <= fix_word;
      s3_data   <= gather(fix_word);
      s3_syn    <= s2_syn;
      s3_status <= fix_status;
    end
  end

  assign out_ch.valid     = s3_valid;
  assign out_ch.code_word = s3_word;
  assign out_ch.data_out  = s3_data;
  assign out_ch.syndrome  = s3_syn;
  assign out_ch.status    = s3_status;

endmodule : hamming_sec_encode_correct
`default_nettype wire

FILE: rtl/core/hsec_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsec_checker
// Port-level checks on the encoder/corrector, bound to the top level.
// ----------------------------------------------------------------------------
module hsec_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [hsec_pkg::CODE_W-1:0]   code_word,
  input wire logic [hsec_pkg::SYN_W-1:0]    syndrome,
  input wire logic [hsec_pkg::STAT_W-1:0]   status
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_word) && $stable(syndrome))
    else $error("stalled result changed");

  // clean result carries a zero syndrome
  a_ok_syn: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == hsec_pkg::ST_OK |-> syndrome == '0)
    else $error("status ok with nonzero syndrome");

  // correction or overrange needs a nonzero syndrome
  a_err_syn: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hsec_pkg::ST_CORRECTED || status == hsec_pkg::ST_BEYOND)
      |-> syndrome != '0)
    else $error("error status with zero syndrome");

  // an accepted request reaches the output while the sink keeps taking
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after three cycles");

endmodule : hsec_checker

bind hamming_sec_encode_correct hsec_checker u_hsec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .code_word (out_ch.code_word),
  .syndrome  (out_ch.syndrome),
  .status    (out_ch.status)
);
`default_nettype wire

FILE: sim/hamming_sec_encode_correct_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_encode_correct_test
// Self-checking bench for the Hamming SEC encoder / corrector. Each accepted
// request is run through a local model of the code (length from the message
// length register, even or odd parity) and the result item is compared field
// by field. Directed items cover the corners; random phases sweep message
// lengths from zero to past the saturation point with clean, single-error,
// double-error and noise words, under random stalls on both channels.
// ----------------------------------------------------------------------------
module hamming_sec_encode_correct_test;

  localparam int CLK_HIGH     = 6;
  localparam int CLK_LOW      = 6;
  localparam int RESET_CYCLES = 4;
  localparam int NUM_PHASES   = 14;
  localparam int PHASE_ITEMS  = 118;
  localparam int HOLD_CYCLES  = 48;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;    // pipeline is 3 deep, a few spare
  localparam int STALL_LIMIT  = 2000; // cycles with no handshake at all

  typedef struct packed {
    logic [hsec_pkg::CODE_W-1:0] code_word;
    logic [hsec_pkg::MSG_W-1:0]  data_out;
    logic [hsec_pkg::SYN_W-1:0]  syndrome;
    logic [hsec_pkg::STAT_W-1:0] status;
  } hsec_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: local copy of the two registers, the code model and the
  // queue of words still owed by the block.
  // --------------------------------------------------------------------------
  class hsec_scoreboard;
    logic [hsec_pkg::LEN_W-1:0] msg_len;
    logic                       odd;
    hsec_result_t               awaited_words[$];
    int                         errors;
    int                         n_encode;
    int                         n_decode;
    int                         n_fixed;
    int                         n_beyond;

    function new();
      msg_len = hsec_pkg::MSG_LEN_RESET;
      odd     = 1'b0;
      errors  = 0;
      n_encode = 0;
      n_decode = 0;
      n_fixed  = 0;
      n_beyond = 0;
    endfunction

    function int pending();
      return awaited_words.size();
    endfunction

    // m saturates at MSG_W; r is the least parity count with m + r + 1 <= 2^r
    function int code_length();
      int m;
      int r;
      int n;
      m = (msg_len > hsec_pkg::MSG_W) ? hsec_pkg::MSG_W : int'(msg_len);
      r = 1;
      while (r < hsec_pkg::PAR_W && m + r + 1 > (1 << r))
        r++;
      n = m + r;
      return (n > hsec_pkg::CODE_W) ? hsec_pkg::CODE_W : n;
    endfunction

    function bit is_pow2(int q);
      return q != 0 && (q & (q - 1)) == 0;
    endfunction

    // XOR over positions covered by check p, p itself left out
    function logic cover_xor(logic [hsec_pkg::CODE_W-1:0] word, int p, int n);
      logic acc;
      int   q;
      acc = 1'b0;
      for (q = 1; q <= n; q++)
        if ((q & p) != 0 && q != p)
          acc ^= word[q-1];
      return acc;
    endfunction

    function hsec_result_t hamming_result(logic op, logic [hsec_pkg::MSG_W-1:0] msg,
                                          logic [hsec_pkg::CODE_W-1:0] rcv);
      hsec_result_t res;
      logic [hsec_pkg::CODE_W-1:0] word;
      logic [hsec_pkg::SYN_W-1:0]  syn;
      int n;
      int q;
      int p;
      int k;
      n    = code_length();
      word = '0;
      syn  = '0;
      res.status = hsec_pkg::ST_OK;
      if (op == hsec_pkg::OP_ENCODE) begin
        k = 0;
        for (q = 1; q <= n; q++)
          if (!is_pow2(q)) begin
            word[q-1] = msg[k];
            k++;
          end
        for (p = 1; p <= n; p = p << 1)
          word[p-1] = cover_xor(word, p, n) ^ odd;
      end else begin
        for (q = 1; q <= n; q++)
          word[q-1] = rcv[q-1];
        for (p = 1; p <= n; p = p << 1)
          if (word[p-1] ^ cover_xor(word, p, n) ^ odd)
            syn = syn | hsec_pkg::SYN_W'(p);
        if (syn != 0) begin
          if (syn <= n) begin
            word[syn-1] = ~word[syn-1];
            res.status  = hsec_pkg::ST_CORRECTED;
          end else begin
            res.status = hsec_pkg::ST_BEYOND;
          end
        end
      end
      res.code_word = word;
      res.syndrome  = syn;
      res.data_out  = '0;
      k = 0;
      for (q = 1; q <= n; q++)
        if (!is_pow2(q)) begin
          res.data_out[k] = word[q-1];
          k++;
        end
      return res;
    endfunction

    function void note_request(logic op, logic [hsec_pkg::MSG_W-1:0] msg,
                               logic [hsec_pkg::CODE_W-1:0] rcv);
      hsec_result_t res;
      res = hamming_result(op, msg, rcv);
      awaited_words.push_back(res);
      if (op == hsec_pkg::OP_ENCODE) begin
        n_encode++;
      end else begin
        n_decode++;
        if (res.status == hsec_pkg::ST_CORRECTED) n_fixed++;
        if (res.status == hsec_pkg::ST_BEYOND) n_beyond++;
      end
    endfunction

    function void check_result(logic [hsec_pkg::CODE_W-1:0] cw,
                               logic [hsec_pkg::MSG_W-1:0] dout,
                               logic [hsec_pkg::SYN_W-1:0] syn,
                               logic [hsec_pkg::STAT_W-1:0] st);
      hsec_result_t want;
      bit bad;
      if (awaited_words.size() == 0) begin
        $display("%0t: result with nothing outstanding: code_word %h", $time, cw);
        errors++;
        return;
      end
      want = awaited_words.pop_front();
      bad  = 1'b0;
      if (cw !== want.code_word) begin
        $display("%0t: code_word expected %h got %h", $time, want.code_word, cw);
        bad = 1'b1;
      end
      if (dout !== want.data_out) begin
        $display("%0t: data_out expected %h got %h", $time, want.data_out, dout);
        bad = 1'b1;
      end
      if (syn !== want.syndrome) begin
        $display("%0t: syndrome expected %0d got %0d", $time, want.syndrome, syn);
        bad = 1'b1;
      end
      if (st !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, st);
        bad = 1'b1;
      end
      if (bad) errors++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT, shared flags
  // --------------------------------------------------------------------------
  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [hsec_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hsec_pkg::CFG_W-1:0]     cfg_data;

  bit long_hold_req = 1'b0; // sender asks, receiver serves and clears
  bit steady_run    = 1'b0; // no idling on either side in the last phase
  int idle_cycles   = 0;

  hsec_scoreboard sb = new();

  hsec_in_if  req_ch ();
  hsec_out_if rsp_ch ();

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  hamming_sec_encode_correct dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch)
  );

  // Settings swept by the random phases; -1 picks a length at random.
  // Covers zero, the tiny codes, a code length that is not 2^r-1 (so
  // syndromes can point past the end), full length and saturating values.
  int phase_len [NUM_PHASES] = '{4, 0, 1, 2, 3, 5, 11, 26, 57, 63, 58, -1, -1, 57};
  bit phase_odd [NUM_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 1, 0, 1, 0, 1, 0};

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off on request so the
  // pipeline fills and backs up onto the request channel.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (!steady_run && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8);
        rsp_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // result monitor: sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.code_word, rsp_ch.data_out, rsp_ch.syndrome,
                      rsp_ch.status);
  end

  // watchdog: any handshake on either channel resets the count
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("hamming_sec_encode_correct verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one item, optionally after a random gap; returns once it is taken.
  task automatic send_item(input logic op, input logic [hsec_pkg::MSG_W-1:0] msg,
                           input logic [hsec_pkg::CODE_W-1:0] rcv);
    int gap;
    if (!steady_run && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid         <= 1'b1;
    req_ch.op            <= op;
    req_ch.message_word  <= msg;
    req_ch.received_word <= rcv;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_request(op, msg, rcv);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Registers only change with the pipeline empty.
  task automatic set_config(input logic [hsec_pkg::LEN_W-1:0] m, input logic odd);
    wait_for_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= hsec_pkg::CFG_MSG_LEN;
    cfg_data  <= hsec_pkg::CFG_W'(m);
    @(negedge clk);
    cfg_index <= hsec_pkg::CFG_ODD;
    cfg_data  <= hsec_pkg::CFG_W'(odd);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.msg_len = m;
    sb.odd     = odd;
  endtask

  function automatic logic [hsec_pkg::CODE_W-1:0] encoded(
    input logic [hsec_pkg::MSG_W-1:0] msg
  );
    hsec_result_t res;
    res = sb.hamming_result(hsec_pkg::OP_ENCODE, msg, '0);
    return res.code_word;
  endfunction

  function automatic logic [hsec_pkg::CODE_W-1:0] rand_code();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[hsec_pkg::CODE_W-1:0];
  endfunction

  function automatic logic [hsec_pkg::MSG_W-1:0] rand_msg();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[hsec_pkg::MSG_W-1:0];
  endfunction

  task automatic directed_checks();
    logic [hsec_pkg::CODE_W-1:0] cw;
    // reset settings: 4 message bits, even parity, 7-bit code
    send_item(hsec_pkg::OP_ENCODE, '0, '0);
    send_item(hsec_pkg::OP_ENCODE, '1, '1);        // excess message bits ignored
    send_item(hsec_pkg::OP_DECODE, '1, '0);
    send_item(hsec_pkg::OP_DECODE, '0, '1);        // bits past the code length ignored
    cw = encoded(57'b1011);
    send_item(hsec_pkg::OP_DECODE, '0, cw ^ 63'b100);   // data bit hit
    send_item(hsec_pkg::OP_DECODE, '0, cw ^ 63'b1000);  // parity bit hit
    // odd parity: all-zero word is no longer a codeword
    set_config(6'd4, 1'b1);
    send_item(hsec_pkg::OP_ENCODE, '0, '0);
    send_item(hsec_pkg::OP_DECODE, '0, '0);
    // zero message length: a lone parity bit
    set_config(6'd0, 1'b0);
    send_item(hsec_pkg::OP_ENCODE, '1, '0);
    send_item(hsec_pkg::OP_DECODE, '0, 63'd1);
    send_item(hsec_pkg::OP_DECODE, '0, '1);
    // length register past the maximum saturates to a full 63-bit code
    set_config(6'd63, 1'b1);
    send_item(hsec_pkg::OP_ENCODE, '1, '0);
    send_item(hsec_pkg::OP_ENCODE, '0, '1);
    send_item(hsec_pkg::OP_DECODE, '0, '1);
    cw = encoded('1);
    send_item(hsec_pkg::OP_DECODE, '0, cw ^ {1'b1, 62'b0});
    // 9-bit code: positions 4 and 8 together point at 12, past the end
    set_config(6'd5, 1'b0);
    send_item(hsec_pkg::OP_DECODE, '0, 63'h88);
    send_item(hsec_pkg::OP_ENCODE, '1, '1);
    set_config(6'd57, 1'b0);
    send_item(hsec_pkg::OP_ENCODE, '1, '0);
    send_item(hsec_pkg::OP_DECODE, '0, 63'd1);
    send_item(hsec_pkg::OP_DECODE, '1, encoded(57'hAAAAAAAAAAAAAA));
  endtask

  // Mostly well-formed traffic: encodes, clean codewords, single errors;
  // a share of double errors and pure noise. Bits above the code length
  // are always random.
  task automatic random_item();
    logic [hsec_pkg::CODE_W-1:0] cw;
    logic [hsec_pkg::CODE_W-1:0] mask;
    logic [hsec_pkg::CODE_W-1:0] noise;
    int n;
    int pick;
    int a;
    int b;
    n     = sb.code_length();
    noise = rand_code();
    pick  = $urandom_range(0, 99);
    if (pick < 40) begin
      send_item(hsec_pkg::OP_ENCODE, rand_msg(), noise);
    end else begin
      cw   = encoded(rand_msg());
      mask = '1;
      mask = mask >> (hsec_pkg::CODE_W - n);
      if (pick >= 58 && pick < 80) begin
        a = $urandom_range(1, n);
        cw[a-1] = ~cw[a-1];
      end else if (pick >= 80 && pick < 90 && n >= 2) begin
        a = $urandom_range(1, n);
        b = $urandom_range(1, n - 1);
        if (b >= a) b++;
        cw[a-1] = ~cw[a-1];
        cw[b-1] = ~cw[b-1];
      end else if (pick >= 90) begin
        cw = rand_code();
      end
      send_item(hsec_pkg::OP_DECODE, rand_msg(), (cw & mask) | (noise & ~mask));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    int item;
    int m;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = hsec_pkg::CFG_MSG_LEN;
    cfg_data             = '0;
    req_ch.valid         = 1'b0;
    req_ch.op            = hsec_pkg::OP_ENCODE;
    req_ch.message_word  = '0;
    req_ch.received_word = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    directed_checks();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      m = (phase_len[phase] < 0) ? $urandom_range(6, 56) : phase_len[phase];
      set_config(hsec_pkg::LEN_W'(m), phase_odd[phase]);
      // last phase runs flat out on both sides
      if (phase == NUM_PHASES - 1) steady_run = 1'b1;
      for (item = 0; item < PHASE_ITEMS; item++) begin
        // receiver holds off while the sender keeps pushing
        if (item == 40 && (phase == 5 || phase == 10)) long_hold_req = 1'b1;
        random_item();
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d encodes and %0d decodes over %0d register settings",
             sb.n_encode, sb.n_decode, NUM_PHASES + 6);
    $display("Decodes: %0d single-bit corrections, %0d syndromes past the code end",
             sb.n_fixed, sb.n_beyond);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hamming_sec_encode_correct verification clean");
    end else begin
      $display("hamming_sec_encode_correct verification failed");
    end
    $finish;
  end

endmodule : hamming_sec_encode_correct_test
